>>> src/b85enc_pkg.sv
`timescale 1ns / 1ps

package b85enc_pkg;

   localparam int GROUP_W   = 32;
   localparam int CHAR_W    = 7;
   localparam int DIGITS    = 5;
   localparam int RADIX     = 85;
   localparam int CHAR_BASE = 33;

   // Reciprocal of 85 scaled by 2^38. The rounding error is 21, and
   // 21 * 2^32 < 2^38, so the quotient is exact for any 32-bit value.
   localparam logic [GROUP_W-1:0] RECIP = 32'd3233857729;
   localparam int RECIP_SHIFT = 38;

   typedef logic [CHAR_W-1:0] digit_type;

   // One 32-bit group queued for conversion
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [2:0]         nchars;
      logic               last;
   } group_type;

   function automatic logic [GROUP_W-1:0] div85(input logic [GROUP_W-1:0] v);
      logic [2*GROUP_W-1:0] prod;
      prod = {{GROUP_W{1'b0}}, v} * {{GROUP_W{1'b0}}, RECIP};
      return GROUP_W'(prod >> RECIP_SHIFT);
   endfunction

endpackage

>>> src/b85enc_front.sv
`timescale 1ns / 1ps

module b85enc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_data
   output logic                  grp_valid,
   input  logic                  grp_ready,
   output b85enc_pkg::group_type grp
);
   import b85enc_pkg::*;

   logic [23:0]        pending_ff;
   logic [1:0]         count_ff, count_in;
   logic               slot_valid_ff, slot_valid_in;
   group_type          slot_ff;
   logic               accept;
   logic               flush;
   logic [2:0]         total;
   logic [GROUP_W-1:0] padded;

   assign req_tready = !slot_valid_ff || grp_ready;
   assign accept     = req_tvalid && req_tready;
   assign flush      = req_tlast || (count_ff == 2'd3);
   assign total      = {1'b0, count_ff} + 3'd1;

   // Zero-pad a short group on the right
   always_comb begin
      case (count_ff)
         2'd0:    padded = {req_tdata, 24'd0};
         2'd1:    padded = {pending_ff[7:0], req_tdata, 16'd0};
         2'd2:    padded = {pending_ff[15:0], req_tdata, 8'd0};
         default: padded = {pending_ff, req_tdata};
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      slot_valid_in = slot_valid_ff;
      if (slot_valid_ff && grp_ready) begin
         slot_valid_in = 1'b0;
      end
      if (accept) begin
         if (flush) begin
            count_in      = 2'd0;
            slot_valid_in = 1'b1;
         end else begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 2'd0;
         slot_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !flush) begin
         pending_ff <= {pending_ff[15:0], req_tdata};
      end
      if (accept && flush) begin
         slot_ff.group  <= padded;
         slot_ff.nchars <= total + 3'd1;
         slot_ff.last   <= req_tlast;
      end
   end

   assign grp_valid = slot_valid_ff;
   assign grp       = slot_ff;

endmodule

>>> src/b85enc_fifo.sv
`timescale 1ns / 1ps

module b85enc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  b85enc_pkg::group_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output b85enc_pkg::group_type pop_data
);
   import b85enc_pkg::*;

   group_type  ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = ent_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/b85enc_back.sv
`timescale 1ns / 1ps

module b85enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  b85enc_pkg::group_type pop_group,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [6:0] char_code, [7] zero fill
   output logic                  rsp_tlast    // last_char
);
   import b85enc_pkg::*;

   // Divider: quo_ff steps through v, v/85, v/85^2 ... and prv_ff trails it
   logic               cv_busy_ff, cv_busy_in;
   logic               cv_done_ff, cv_done_in;
   logic [2:0]         step_ff, step_in;
   logic [GROUP_W-1:0] quo_ff, quo_in;
   logic [GROUP_W-1:0] prv_ff, prv_in;
   digit_type          dig_ff [DIGITS];
   logic [2:0]         cv_n_ff;
   logic               cv_last_ff;
   logic [GROUP_W-1:0] prod85;
   logic [GROUP_W-1:0] diff;
   logic [2:0]         wr_idx;

   // Emitter: walks the finished digits, most significant first
   logic               em_valid_ff, em_valid_in;
   digit_type          em_dig_ff [DIGITS];
   logic [2:0]         em_idx_ff, em_idx_in;
   logic [2:0]         em_n_ff;
   logic               em_last_ff;

   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff;
   logic               out_last_ff;

   logic               out_free;
   logic               em_fire;
   logic               em_final;
   logic               em_free;
   logic               handoff;
   logic               start;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign em_fire   = em_valid_ff && out_free;
   assign em_final  = (em_idx_ff == em_n_ff - 3'd1);
   assign em_free   = !em_valid_ff || (em_fire && em_final);
   assign handoff   = cv_done_ff && em_free;
   assign pop_ready = !cv_busy_ff && (!cv_done_ff || handoff);
   assign start     = pop_valid && pop_ready;

   assign prod85 = quo_ff * GROUP_W'(RADIX);
   assign diff   = prv_ff - prod85;
   assign wr_idx = 3'(DIGITS) - step_ff;

   always_comb begin
      cv_busy_in = cv_busy_ff;
      cv_done_in = cv_done_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      prv_in     = prv_ff;
      if (cv_busy_ff) begin
         quo_in  = div85(quo_ff);
         prv_in  = quo_ff;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'(DIGITS - 1)) begin
            cv_busy_in = 1'b0;
            cv_done_in = 1'b1;
         end
      end else if (handoff) begin
         cv_done_in = 1'b0;
      end
      if (start) begin
         cv_busy_in = 1'b1;
         quo_in     = pop_group.group;
         step_in    = 3'd0;
      end
   end

   always_comb begin
      em_valid_in = em_valid_ff;
      em_idx_in   = em_idx_ff;
      if (em_fire) begin
         em_idx_in = em_idx_ff + 3'd1;
         if (em_final) begin
            em_valid_in = 1'b0;
         end
      end
      if (handoff) begin
         em_valid_in = 1'b1;
         em_idx_in   = 3'd0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (em_fire) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_busy_ff   <= 1'b0;
         cv_done_ff   <= 1'b0;
         step_ff      <= 3'd0;
         em_valid_ff  <= 1'b0;
         em_idx_ff    <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cv_busy_ff   <= cv_busy_in;
         cv_done_ff   <= cv_done_in;
         step_ff      <= step_in;
         em_valid_ff  <= em_valid_in;
         em_idx_ff    <= em_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      prv_ff <= prv_in;
      if (start) begin
         cv_n_ff    <= pop_group.nchars;
         cv_last_ff <= pop_group.last;
      end
      if (cv_busy_ff && step_ff != 3'd0) begin
         dig_ff[wr_idx] <= diff[CHAR_W-1:0];
      end
      if (cv_busy_ff && step_ff == 3'(DIGITS - 1)) begin
         dig_ff[0] <= quo_ff[CHAR_W-1:0];
      end
      if (handoff) begin
         em_dig_ff  <= dig_ff;
         em_n_ff    <= cv_n_ff;
         em_last_ff <= cv_last_ff;
      end
      if (em_fire) begin
         out_char_ff <= em_dig_ff[em_idx_ff] + CHAR_W'(CHAR_BASE);
         out_last_ff <= em_last_ff && em_final;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/base85_stream_encoder.sv
// Base-85 stream encoder. Send raw bytes on the req_ channel, one per transfer, with
// req_tlast on the final byte of a stream; read ASCII characters '!' .. 'u' on the rsp_
// channel, five per full 4-byte big-endian group, most significant digit first, and n+1
// for a final short group of n bytes (zero-padded). rsp_tlast marks the last character
// of the stream; there is no 'z' shortcut and no delimiters, and a new stream may follow
// at once. The front gathers bytes and takes one per cycle while its two-entry group
// queue has room; the back converts a group in five divide steps through a single
// multiply-by-reciprocal divide-by-85 unit (one division a cycle) and then sends one
// character a cycle, unless rsp_tready holds it, while the next group converts.
// Sustained throughput is set by that divider, which takes the next group as it hands the
// digits to the character stage. A closed group goes through the front's slot, the
// queue, the divider, the emitter and the output register before rsp_tvalid rises.
`timescale 1ns / 1ps

module base85_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // end_of_data
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] char_code, [7] zero fill
   output logic       rsp_tlast     // last_char
);
   import b85enc_pkg::*;

   // Front to queue: one padded group per transfer
   logic      grp_valid;
   logic      grp_ready;
   group_type grp;

   // Queue to back
   logic      pop_valid;
   logic      pop_ready;
   group_type pop_group;

   // Gather bytes; close a group on the fourth byte or on the end mark
   b85enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp)
   );

   // Hold up to two groups so the front keeps taking bytes while the back works
   b85enc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (grp_valid),
      .push_ready (grp_ready),
      .push_data  (grp),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_group)
   );

   // Split each group into base-85 digits and stream them out as characters
   b85enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // Every character must be a valid base-85 digit code
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] >= 7'd33) && (rsp_tdata[6:0] <= 7'd117))
      else $error("character code out of base-85 range");

   // A queued group yields between two and five characters
   a_group_len: assert property (@(posedge clock) disable iff (reset)
      grp_valid |-> (grp.nchars >= 3'd2) && (grp.nchars <= 3'd5))
      else $error("group character count out of range");

   // The byte carrying the end mark must flush its group right away
   a_end_flush: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (grp_valid && grp.last))
      else $error("end of stream did not flush the open group");
`endif

endmodule
